/* sv/wsi_pkg.sv */
package wsi_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // capture input payload, slot <= count
    logic drop;      // store full: flag the run
    logic rd_slot;   // read store[slot-1]
    logic shift_wr;  // store[slot] <= read data, slot--, read store[slot-2]
    logic place_wr;  // store[slot] <= new value, count++
    logic emit_init; // set up read pointers for the wiggle order
    logic emit_rd;   // read next wiggle entry, advance its pointer
    logic out_load;  // load result register from read data
    logic clear_run; // run done: count and flag back to zero
  } wsi_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic slot_zero;
    logic slot_one;
    logic gt;        // held value sorts after the new one
    logic last;
    logic out_last;
  } wsi_sts_t;

endpackage

/* sv/wsi_if.sv */
interface wsi_in_if;
  import wsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_in;
  logic                     last_in;
  modport source (output valid, output value_in, output last_in, input ready);
  modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface wsi_out_if;
  import wsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_out;
  logic        [POS_W-1:0]  position;
  logic                     last_out;
  logic                     overflow;
  modport source (output valid, output value_out, output position, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input value_out, input position, input last_out,
                  input overflow, output ready);
endinterface

interface wsi_cfg_if;
  logic valid;
  logic ready;
  logic interleave_mode;
  modport source (output valid, output interleave_mode, input ready);
  modport sink   (input valid, input interleave_mode, output ready);
endinterface

/* sv/wsi_ram.sv */
module wsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/wsi_ctrl.sv */
module wsi_ctrl
  import wsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  wsi_sts_t sts,
  output wsi_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ACC   = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_PLACE = 8'b0000_1000,
    S_EMI   = 8'b0001_0000,
    S_EMRD  = 8'b0010_0000,
    S_EMLD  = 8'b0100_0000,
    S_EMWT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMWT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        if (sts.full) begin
          cmd.drop  = 1'b1;
          state_nxt = sts.last ? S_EMI : S_IDLE;
        end else if (sts.slot_zero) begin
          cmd.place_wr = 1'b1;
          state_nxt    = sts.last ? S_EMI : S_IDLE;
        end else begin
          cmd.rd_slot = 1'b1;
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.gt) begin
          cmd.shift_wr = 1'b1;
          state_nxt    = sts.slot_one ? S_PLACE : S_SHIFT;
        end else begin
          cmd.place_wr = 1'b1;
          state_nxt    = sts.last ? S_EMI : S_IDLE;
        end
      end
      S_PLACE: begin
        cmd.place_wr = 1'b1;
        state_nxt    = sts.last ? S_EMI : S_IDLE;
      end
      S_EMI: begin
        cmd.emit_init = 1'b1;
        state_nxt     = S_EMRD;
      end
      S_EMRD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMLD;
      end
      S_EMLD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_EMWT;
      end
      S_EMWT: begin
        if (out_ready) begin
          if (sts.out_last) begin
            cmd.clear_run = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.emit_rd = 1'b1;
            state_nxt   = S_EMLD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/wsi_dp.sv */
module wsi_dp
  import wsi_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wsi_cmd_t                 cmd,
  output wsi_sts_t                 sts,
  input  logic signed [DATA_W-1:0] value_in,
  input  logic                     last_in,
  input  logic                     cfg_we,
  input  logic                     cfg_mode,
  output logic signed [DATA_W-1:0] value_out,
  output logic        [POS_W-1:0]  position,
  output logic                     last_out,
  output logic                     overflow
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic              dropped_r, dropped_nxt;
  logic              mode_r;
  logic [DATA_W-1:0] val_r;
  logic              last_r;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [DATA_W-1:0] out_val_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [CW:0]       n_p1;
  logic [AW-1:0]     mid_a;

  wsi_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign n_p1  = {1'b0, count_r} + (CW+1)'(1);
  assign mid_a = AW'(n_p1 >> 1);

  always_comb begin
    ram_we    = cmd.shift_wr | cmd.place_wr;
    ram_waddr = slot_r;
    ram_wdata = cmd.shift_wr ? ram_rdata : val_r;
    ram_re    = cmd.rd_slot | cmd.shift_wr | cmd.emit_rd;
    priority if (cmd.rd_slot) begin
      ram_raddr = slot_r - AW'(1);
    end else if (cmd.shift_wr) begin
      ram_raddr = slot_r - AW'(2);
    end else begin
      ram_raddr = k_r[0] ? hi_r : lo_r;
    end
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    slot_nxt    = slot_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    k_nxt       = k_r;
    if (cmd.accept) begin
      slot_nxt = AW'(count_r);
    end
    if (cmd.drop) begin
      dropped_nxt = 1'b1;
    end
    if (cmd.shift_wr) begin
      slot_nxt = slot_r - AW'(1);
    end
    if (cmd.place_wr) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.emit_init) begin
      k_nxt = '0;
      if (mode_r) begin
        lo_nxt = '0;
        hi_nxt = mid_a;
      end else begin
        lo_nxt = mid_a - AW'(1);
        hi_nxt = AW'(count_r - CW'(1));
      end
    end
    // even positions take from the lower half, odd from the upper half
    if (cmd.emit_rd) begin
      if (k_r[0]) begin
        hi_nxt = mode_r ? hi_r + AW'(1) : hi_r - AW'(1);
      end else begin
        lo_nxt = mode_r ? lo_r + AW'(1) : lo_r - AW'(1);
      end
    end
    if (cmd.out_load) begin
      k_nxt = k_r + CW'(1);
    end
    if (cmd.clear_run) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      mode_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_we) begin
        mode_r <= cfg_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    k_r    <= k_nxt;
    if (cmd.accept) begin
      val_r  <= value_in;
      last_r <= last_in;
    end
    if (cmd.out_load) begin
      out_val_r  <= ram_rdata;
      out_pos_r  <= POS_W'(k_r);
      out_last_r <= (k_r + CW'(1)) == count_r;
      out_ovf_r  <= dropped_r;
    end
  end

  assign sts.full      = (count_r == CW'(MAX_ELEMENTS));
  assign sts.slot_zero = (slot_r == '0);
  assign sts.slot_one  = (slot_r == AW'(1));
  assign sts.gt        = ($signed(ram_rdata) > $signed(val_r));
  assign sts.last      = last_r;
  assign sts.out_last  = out_last_r;

  assign value_out = out_val_r;
  assign position  = out_pos_r;
  assign last_out  = out_last_r;
  assign overflow  = out_ovf_r;

endmodule

/* sv/wiggle_sort_interleaver_core.sv */
// Wiggle sort interleaver. Values stream in one per transfer and are insertion-sorted
// into a single-port-write RAM of MAX_ELEMENTS entries; a transfer with last_in set ends
// the set and the block then streams all n held values in wiggle order (even positions
// from the lower half, odd from the upper half; mode 0 walks both halves from the top
// down, mode 1 from the bottom up). Values beyond MAX_ELEMENTS are dropped and every
// result of that run carries overflow. Each input is placed by shifting every held value
// larger than it up one entry, one RAM entry per cycle; into an empty store it is written
// directly, into a full one it is dropped. A run ending sets up the read pointers, then
// each result is read from RAM, loaded into the result register and held there until the
// sink is ready. in_ready is high only while the block waits for input. interleave_mode
// is written through the cfg channel, always ready, and should change only between runs.
module wiggle_sort_interleaver_core
  import wsi_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  wsi_in_if.sink     in_ch,
  wsi_out_if.source  out_ch,
  wsi_cfg_if.sink    cfg_ch
);

  wsi_cmd_t cmd;
  wsi_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  wsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsi_dp #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .value_in (in_ch.value_in),
    .last_in  (in_ch.last_in),
    .cfg_we   (cfg_ch.valid),
    .cfg_mode (cfg_ch.interleave_mode),
    .value_out(out_ch.value_out),
    .position (out_ch.position),
    .last_out (out_ch.last_out),
    .overflow (out_ch.overflow)
  );

endmodule

/* tb/sv/wsi_result_checker.sv */
`timescale 1ns / 100ps

module wsi_result_checker
  import wsi_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  wsi_in_if    in_ch,
  wsi_out_if   out_ch,
  wsi_cfg_if   cfg_ch,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic        [POS_W-1:0]  position;
    logic                     last;
    logic                     overflow;
  } wiggle_res_t;

  logic signed [DATA_W-1:0] held [MAX_ELEMENTS];
  int                       held_count;
  logic                     dropped;
  logic                     mode;
  wiggle_res_t              wiggle_due [$];
  int                       errs = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic insert_sorted(input logic signed [DATA_W-1:0] v);
    int slot;
    slot = held_count;
    // equal values stay ahead of the new one
    while (slot > 0 && held[slot-1] > v) begin
      held[slot] = held[slot-1];
      slot--;
    end
    held[slot] = v;
    held_count++;
  endtask

  task automatic queue_wiggle_order();
    int          n;
    int          mid;
    int          lo;
    int          hi;
    int          pick;
    wiggle_res_t r;
    n   = held_count;
    mid = (n + 1) / 2;
    if (mode) begin
      lo = 0;
      hi = mid;
    end else begin
      lo = mid - 1;
      hi = n - 1;
    end
    for (int k = 0; k < n; k++) begin
      if (k % 2 == 0) begin
        pick = lo;
        lo   = mode ? lo + 1 : lo - 1;
      end else begin
        pick = hi;
        hi   = mode ? hi + 1 : hi - 1;
      end
      r.value    = held[pick];
      r.position = k[POS_W-1:0];
      r.last     = (k == n - 1);
      r.overflow = dropped;
      wiggle_due.push_back(r);
    end
    held_count = 0;
    dropped    = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    wiggle_res_t want;
    if (!rst_n) begin
      held_count = 0;
      dropped    = 1'b0;
      mode       = 1'b0;
      wiggle_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        mode = cfg_ch.interleave_mode;

      if (out_ch.valid && out_ch.ready) begin
        if (wiggle_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: got value %0d position %0d last %0b overflow %0b",
                   $time, out_ch.value_out, out_ch.position, out_ch.last_out, out_ch.overflow);
        end else begin
          want = wiggle_due.pop_front();
          if (out_ch.value_out !== want.value || out_ch.position !== want.position ||
              out_ch.last_out !== want.last || out_ch.overflow !== want.overflow) begin
            errs++;
            $display("%0t: result mismatch: expected value %0d position %0d last %0b overflow %0b",
                     $time, want.value, want.position, want.last, want.overflow);
            $display("%0t:                  actual value %0d position %0d last %0b overflow %0b",
                     $time, out_ch.value_out, out_ch.position, out_ch.last_out,
                     out_ch.overflow);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (held_count < MAX_ELEMENTS)
          insert_sorted(in_ch.value_in);
        else
          dropped = 1'b1;
        if (in_ch.last_in)
          queue_wiggle_order();
      end
    end
    mismatches <= errs;
    pending    <= wiggle_due.size();
  end

endmodule

/* tb/sv/wiggle_sort_interleaver_core_tb.sv */
`timescale 1ns / 100ps

module wiggle_sort_interleaver_core_tb;
  import wsi_pkg::*;

  localparam int MAX_ELEMENTS  = 64;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 200;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  bit   calm;
  int   fails;
  int   pending;
  int   items_sent = 0;

  wsi_in_if  in_ch ();
  wsi_out_if out_ch ();
  wsi_cfg_if cfg_ch ();

  wiggle_sort_interleaver_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wsi_result_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (fails),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 98)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  initial begin : sink_stall
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat (1 + $urandom_range(0, 12)) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_value(input logic signed [DATA_W-1:0] v, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.value_in <= v;
    in_ch.last_in  <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold off input until every result is back and the sorter is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.interleave_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_set(input int size, input int style);
    logic signed [DATA_W-1:0] v;
    int                       step;
    step = $urandom_range(1, 1000);
    for (int i = 0; i < size; i++) begin
      case (style)
        0: v = $urandom;
        1: v = int'($urandom_range(0, 8)) - 4;
        2: begin
          case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '0;
            3: v = '1;
            default: v = $urandom;
          endcase
        end
        3: v = 32'sh7FFF_FFFF - i * step;  // descending: every new value sinks to the bottom
        default: v = 32'sh8000_0000 + i * step;
      endcase
      send_value(v, i == size - 1);
    end
  endtask

  initial begin : stimulus
    int stop;
    int phase;
    int sets;
    int size;
    int r;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.value_in         <= '0;
    in_ch.last_in          <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.interleave_mode <= 1'b0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // mode 0 from reset: single element, extremes, duplicates
    send_value(32'h8000_0000, 1'b1);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_0001, 1'b1);
    send_value(5, 1'b0);
    send_value(5, 1'b0);
    send_value(-3, 1'b0);
    send_value(5, 1'b1);
    drain();
    write_mode(1'b1);
    send_value(10, 1'b0);
    send_value(-10, 1'b1);
    for (int i = 0; i < 7; i++)
      send_value(100 - 10 * i, i == 6);
    drain();
    write_mode(1'b0);

    stop  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < stop) begin
      drain();
      write_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      sets = $urandom_range(1, 4);
      for (int s = 0; s < sets && items_sent < stop; s++) begin
        r = $urandom_range(0, 99);
        if (phase == 0 && s == 0)
          size = MAX_ELEMENTS + 1;  // store full, the last transfer itself is dropped
        else if (r < 70)
          size = $urandom_range(1, 8);
        else if (r < 92)
          size = $urandom_range(9, 30);
        else
          size = $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 6);
        if (size > stop - items_sent)
          size = stop - items_sent;
        send_set(size, $urandom_range(0, 4));
        if ($urandom_range(0, 4) == 0)
          drain();
      end
      phase++;
    end
    calm = 1'b0;
    drain();

    if (fails == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/wsi_pkg.sv
sv/wsi_if.sv
sv/wsi_ram.sv
sv/wsi_ctrl.sv
sv/wsi_dp.sv
sv/wiggle_sort_interleaver_core.sv
tb/sv/wsi_result_checker.sv
tb/sv/wiggle_sort_interleaver_core_tb.sv
